// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is low.
`define HFA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define HFA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/hfa_pkg.sv =====
// Types, constants and codes shared by the hole fit allocator files.
`timescale 1ns / 1ps
package hfa_pkg;

  localparam int NUM_HOLES   = 16;
  localparam int ADDR_W      = (NUM_HOLES > 1) ? $clog2(NUM_HOLES) : 1;
  localparam int CNT_W       = $clog2(NUM_HOLES + 1);
  localparam int SIZE_W      = 16;
  localparam int SLOT_W      = 4;
  localparam int HC_W        = 5;
  localparam int POL_W       = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 5;
  localparam int INDEX_LIMIT = 16;
  localparam int SCAN_MAX    = (NUM_HOLES < INDEX_LIMIT) ? NUM_HOLES : INDEX_LIMIT;

  // Fit policy codes; the unused code behaves as first fit.
  localparam logic [POL_W-1:0] POLICY_FIRST = 2'd0;
  localparam logic [POL_W-1:0] POLICY_BEST  = 2'd1;
  localparam logic [POL_W-1:0] POLICY_WORST = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLE_COUNT = 2'd1;

  // Input item kinds.
  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  // Hole table access from the sequencer.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [SIZE_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } hfa_store_req_t;

  // Compare inputs for the fit unit.
  typedef struct packed {
    logic [POL_W-1:0]  policy;
    logic [SIZE_W-1:0] amount;
    logic [SIZE_W-1:0] hole;
    logic [SIZE_W-1:0] best;
    logic              found;
  } hfa_fit_req_t;

  // Compare results from the fit unit.
  typedef struct packed {
    logic take;
    logic grant;
  } hfa_fit_rsp_t;

endpackage

// ===== rtl/hfa_channels.sv =====
// Valid/ready channel interfaces for requests, results and configuration.
`timescale 1ns / 1ps
interface hfa_in_if;
  import hfa_pkg::*;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [SLOT_W-1:0] slot;
  logic [SIZE_W-1:0] amount;
  modport source (output valid, output kind, output slot, output amount, input ready);
  modport sink   (input valid, input kind, input slot, input amount, output ready);
endinterface

interface hfa_out_if;
  import hfa_pkg::*;
  logic              valid;
  logic              ready;
  logic              granted;
  logic [SLOT_W-1:0] hole_index;
  logic [SIZE_W-1:0] size_before;
  modport source (output valid, output granted, output hole_index, output size_before,
                  input ready);
  modport sink   (input valid, input granted, input hole_index, input size_before,
                  output ready);
endinterface

interface hfa_cfg_if;
  import hfa_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/hfa_hole_store.sv =====
// Hole size table: one write port, one read port, cleared by reset.
`timescale 1ns / 1ps
module hfa_hole_store (
  input  logic                        clk,
  input  logic                        rst_n,
  input  hfa_pkg::hfa_store_req_t     req,
  output logic [hfa_pkg::SIZE_W-1:0]  rdata
);
  import hfa_pkg::*;

  logic [SIZE_W-1:0] sizes_r [NUM_HOLES];

  // Clear on reset, write one entry on request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_HOLES; i++) begin
        sizes_r[i] <= '0;
      end
    end else if (req.we) begin
      sizes_r[req.waddr] <= req.wdata;
    end
  end

  // Read the entry under the scan pointer
  assign rdata = sizes_r[req.raddr];

endmodule

// ===== rtl/hfa_fit_unit.sv =====
// Shared compare unit: decides whether the scanned hole replaces the pick.
`timescale 1ns / 1ps
module hfa_fit_unit (
  input  hfa_pkg::hfa_fit_req_t req,
  output hfa_pkg::hfa_fit_rsp_t rsp
);
  import hfa_pkg::*;

  logic fits;
  logic larger;
  logic smaller;

  assign fits    = req.hole >= req.amount;
  assign larger  = req.hole > req.best;
  assign smaller = req.hole < req.best;

  // Select the policy rule; ties keep the earlier pick
  always_comb begin
    case (req.policy)
      POLICY_WORST: rsp.take = !req.found || larger;
      POLICY_BEST:  rsp.take = fits && (!req.found || smaller);
      default:      rsp.take = fits && !req.found;
    endcase
    // Final check on the pick: worst fit may hold a hole that is too small
    rsp.grant = req.found && (req.best >= req.amount);
  end

endmodule

// ===== rtl/hfa_ctrl.sv =====
// Sequencer: configuration registers, hole scan and result register.
`timescale 1ns / 1ps
module hfa_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_kind,
  input  logic [hfa_pkg::SLOT_W-1:0]    in_slot,
  input  logic [hfa_pkg::SIZE_W-1:0]    in_amount,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_granted,
  output logic [hfa_pkg::SLOT_W-1:0]    out_hole_index,
  output logic [hfa_pkg::SIZE_W-1:0]    out_size_before,
  // configuration channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [hfa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hfa_pkg::CFG_DATA_W-1:0] cfg_data,
  // hole table and compare unit
  output hfa_pkg::hfa_store_req_t       store_req,
  input  logic [hfa_pkg::SIZE_W-1:0]    store_rdata,
  output hfa_pkg::hfa_fit_req_t         fit_req,
  input  hfa_pkg::hfa_fit_rsp_t         fit_rsp
);
  import hfa_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_WB   = 2'd2;

  logic [1:0]        state_r,  state_nxt;
  logic [ADDR_W-1:0] idx_r,    idx_nxt;
  logic [CNT_W-1:0]  n_r,      n_nxt;
  logic [SIZE_W-1:0] amt_r,    amt_nxt;
  logic [POL_W-1:0]  pol_r,    pol_nxt;
  logic              found_r,  found_nxt;
  logic [SIZE_W-1:0] best_r,   best_nxt;
  logic [ADDR_W-1:0] pick_r,   pick_nxt;
  logic [POL_W-1:0]  fit_policy_r;
  logic [HC_W-1:0]   hole_count_r;
  logic              ov_r,     ov_nxt;
  logic              og_r,     og_nxt;
  logic [SLOT_W-1:0] oi_r,     oi_nxt;
  logic [SIZE_W-1:0] os_r,     os_nxt;

  logic [HC_W-1:0]   scan_n5;
  logic [CNT_W-1:0]  scan_n;
  logic              slot_ok;
  logic              last;

  // Clamp the scan length to the table and to the index width
  assign scan_n5 = (hole_count_r > HC_W'(SCAN_MAX)) ? HC_W'(SCAN_MAX) : hole_count_r;
  assign scan_n  = CNT_W'(scan_n5);
  assign slot_ok = (9'(in_slot) < 9'(NUM_HOLES));
  assign last    = ((CNT_W'(idx_r) + CNT_W'(1)) == n_r);

  assign fit_req.policy = pol_r;
  assign fit_req.amount = amt_r;
  assign fit_req.hole   = store_rdata;
  assign fit_req.best   = best_r;
  assign fit_req.found  = found_r;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;

  // Next state of the scan sequencer and result register
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    n_nxt     = n_r;
    amt_nxt   = amt_r;
    pol_nxt   = pol_r;
    found_nxt = found_r;
    best_nxt  = best_r;
    pick_nxt  = pick_r;
    ov_nxt    = ov_r;
    og_nxt    = og_r;
    oi_nxt    = oi_r;
    os_nxt    = os_r;
    store_req.we    = 1'b0;
    store_req.waddr = pick_r;
    store_req.wdata = best_r - amt_r;
    store_req.raddr = idx_r;

    // drop the result once taken
    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_kind == KIND_LOAD) begin
            store_req.we    = slot_ok;
            store_req.waddr = ADDR_W'(in_slot);
            store_req.wdata = in_amount;
          end else begin
            amt_nxt   = in_amount;
            pol_nxt   = fit_policy_r;
            n_nxt     = scan_n;
            idx_nxt   = '0;
            found_nxt = 1'b0;
            state_nxt = (scan_n == '0) ? ST_WB : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (fit_rsp.take) begin
          best_nxt  = store_rdata;
          pick_nxt  = idx_r;
          found_nxt = 1'b1;
        end
        if (last) begin
          state_nxt = ST_WB;
        end else begin
          idx_nxt = idx_r + ADDR_W'(1);
        end
      end
      ST_WB: begin
        // hold until the result register is free, then shrink the hole
        if (!ov_r || out_ready) begin
          ov_nxt       = 1'b1;
          og_nxt       = fit_rsp.grant;
          oi_nxt       = fit_rsp.grant ? SLOT_W'(pick_r) : '0;
          os_nxt       = fit_rsp.grant ? best_r : '0;
          store_req.we = fit_rsp.grant;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Scan and result payload registers
  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    n_r     <= n_nxt;
    amt_r   <= amt_nxt;
    pol_r   <= pol_nxt;
    found_r <= found_nxt;
    best_r  <= best_nxt;
    pick_r  <= pick_nxt;
    og_r    <= og_nxt;
    oi_r    <= oi_nxt;
    os_r    <= os_nxt;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_policy_r <= POLICY_FIRST;
      hole_count_r <= HC_W'(16);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FIT_POLICY: fit_policy_r <= cfg_data[POL_W-1:0];
        CFG_HOLE_COUNT: hole_count_r <= cfg_data[HC_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_valid       = ov_r;
  assign out_granted     = og_r;
  assign out_hole_index  = oi_r;
  assign out_size_before = os_r;

endmodule

// ===== rtl/hole_fit_allocator.sv =====
// Hole fit allocator: the table of free hole sizes with first, best and worst fit.
//
// Channels: in_ch takes load and allocation requests, out_ch returns one result
// per allocation request, cfg_ch writes fit_policy (index 0) and hole_count
// (index 1). All use valid/ready; a request moves when both are high.
// A load request is written to the table in the cycle it is accepted and gives
// no result; the next request can follow in the next cycle.
// An allocation request holds in_ready low after it is accepted, while the
// block scans n holes, where n is hole_count clamped to the table size: one
// compare unit examines one hole per cycle, then the write-back state writes
// the shrunken hole back and registers the result. With a hole count of zero
// the scan is skipped and the request goes straight to write-back.
// If the receiver stalls, the finished result holds in the output register,
// and the block accepts new requests; a second result waits in write-back
// until the first one is taken.
// Reset clears the table to zero, selects first fit and uses all 16 holes.
// Configuration is always ready and is meant to be written while idle.
`timescale 1ns / 1ps
module hole_fit_allocator (
  input  logic       clk,
  input  logic       rst_n,
  hfa_in_if.sink     in_ch,
  hfa_out_if.source  out_ch,
  hfa_cfg_if.sink    cfg_ch
);
  import hfa_pkg::*;

  hfa_store_req_t    store_req;
  logic [SIZE_W-1:0] store_rdata;
  hfa_fit_req_t      fit_req;
  hfa_fit_rsp_t      fit_rsp;

  hfa_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_kind         (in_ch.kind),
    .in_slot         (in_ch.slot),
    .in_amount       (in_ch.amount),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_granted     (out_ch.granted),
    .out_hole_index  (out_ch.hole_index),
    .out_size_before (out_ch.size_before),
    .cfg_valid       (cfg_ch.valid),
    .cfg_ready       (cfg_ch.ready),
    .cfg_index       (cfg_ch.index),
    .cfg_data        (cfg_ch.data),
    .store_req       (store_req),
    .store_rdata     (store_rdata),
    .fit_req         (fit_req),
    .fit_rsp         (fit_rsp)
  );

  hfa_hole_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (store_req),
    .rdata (store_rdata)
  );

  hfa_fit_unit u_fit (
    .req (fit_req),
    .rsp (fit_rsp)
  );

endmodule

// ===== rtl/hfa_checker.sv =====
// Port-level checks for the hole fit allocator, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module hfa_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       in_kind,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_granted,
  input logic [hfa_pkg::SLOT_W-1:0] out_hole_index,
  input logic [hfa_pkg::SIZE_W-1:0] out_size_before
);
  import hfa_pkg::*;

  // A refused request reports no hole
  `HFA_ASSERT(a_refused_zero, clk, rst_n, (out_valid && !out_granted) |-> (out_hole_index == '0 && out_size_before == '0), "refused result carries a hole")

  // An allocation request busies the block for its scan
  `HFA_ASSERT(a_busy_after_alloc, clk, rst_n, (in_valid && in_ready && in_kind == KIND_REQUEST) |=> !in_ready, "ready stayed high after an allocation request")

  // A stalled result holds
  `HFA_ASSERT(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(out_granted) && $stable(out_hole_index) && $stable(out_size_before)), "stalled result changed")

  // Reset leaves the block idle with no result
  `HFA_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> (!out_valid && in_ready), "block not idle after reset")

endmodule

bind hole_fit_allocator hfa_checker u_hfa_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_kind         (in_ch.kind),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_granted     (out_ch.granted),
  .out_hole_index  (out_ch.hole_index),
  .out_size_before (out_ch.size_before)
);

// ===== verif/tb_top.sv =====
// Self-checking testbench for the hole fit allocator: directed table, then random traffic.
`timescale 1ns / 1ps
module tb_top;
  import hfa_pkg::*;

  localparam int PHASE_ITEMS    = 610;
  localparam int DRAIN_CYCLES   = 24;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int MAX_REPORTS    = 10;

  // Spare policy code; the block treats it as first fit.
  localparam logic [POL_W-1:0] POLICY_SPARE = 2'd3;

  typedef struct packed {
    logic              granted;
    logic [SLOT_W-1:0] hole_index;
    logic [SIZE_W-1:0] size_before;
  } grant_t;

  typedef enum logic [1:0] {ROW_LOAD, ROW_REQ, ROW_CFG} row_op_t;

  typedef struct {
    row_op_t               op;
    logic [SLOT_W-1:0]     slot;
    logic [SIZE_W-1:0]     amount;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    bit                    typed;
    grant_t                want;
  } dir_row_t;

  logic clk;
  logic rst_n;

  hfa_in_if  in_if ();
  hfa_out_if out_if ();
  hfa_cfg_if cfg_if ();

  hole_fit_allocator u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // Shadow copy of the hole table and registers
  logic [SIZE_W-1:0] hole_tbl [NUM_HOLES];
  logic [POL_W-1:0]  fit_pol;
  logic [HC_W-1:0]   hole_cnt;

  grant_t   grant_q [$];
  dir_row_t dir_tbl [$];

  int err_cnt = 0;
  int n_items = 0;
  int n_results = 0;
  int n_grants = 0;
  int n_cfg = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Hold every input at a known value from time zero
  initial begin
    rst_n         = 1'b0;
    in_if.valid   = 1'b0;
    in_if.kind    = KIND_LOAD;
    in_if.slot    = '0;
    in_if.amount  = '0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = CFG_FIT_POLICY;
    cfg_if.data   = '0;
    out_if.ready  = 1'b0;
    foreach (hole_tbl[i]) hole_tbl[i] = '0;
    fit_pol  = POLICY_FIRST;
    hole_cnt = 5'd16;
  end

  // Work out the result of one request and update the shadow table
  function automatic bit predict_fit(input logic kind, input logic [SLOT_W-1:0] slot,
                                     input logic [SIZE_W-1:0] amount, output grant_t g);
    int  n;
    int  pick;
    bit  found;
    g     = '0;
    pick  = 0;
    found = 1'b0;
    if (kind == KIND_LOAD) begin
      if (int'(slot) < NUM_HOLES) hole_tbl[slot] = amount;
      return 1'b0;
    end
    n = int'(hole_cnt);
    if (n > SCAN_MAX) n = SCAN_MAX;
    case (fit_pol)
      POLICY_WORST: begin
        for (int i = 0; i < n; i++)
          if (!found || hole_tbl[i] > hole_tbl[pick]) begin
            pick  = i;
            found = 1'b1;
          end
        if (found && hole_tbl[pick] < amount) found = 1'b0;
      end
      POLICY_BEST: begin
        for (int i = 0; i < n; i++)
          if (hole_tbl[i] >= amount && (!found || hole_tbl[i] < hole_tbl[pick])) begin
            pick  = i;
            found = 1'b1;
          end
      end
      default: begin
        for (int i = 0; i < n && !found; i++)
          if (hole_tbl[i] >= amount) begin
            pick  = i;
            found = 1'b1;
          end
      end
    endcase
    if (found) begin
      g.granted     = 1'b1;
      g.hole_index  = pick[SLOT_W-1:0];
      g.size_before = hole_tbl[pick];
      hole_tbl[pick] = hole_tbl[pick] - amount;
    end
    return 1'b1;
  endfunction

  function automatic dir_row_t mk_row(input row_op_t op, input int a, input int b,
                                      input bit typed = 1'b0, input int w_grant = 0,
                                      input int w_idx = 0, input int w_size = 0);
    dir_row_t r;
    r.op                 = op;
    r.slot               = a[SLOT_W-1:0];
    r.cfg_idx            = a[CFG_IDX_W-1:0];
    r.amount             = b[SIZE_W-1:0];
    r.cfg_data           = b[CFG_DATA_W-1:0];
    r.typed              = typed;
    r.want.granted       = w_grant[0];
    r.want.hole_index    = w_idx[SLOT_W-1:0];
    r.want.size_before   = w_size[SIZE_W-1:0];
    return r;
  endfunction

  task automatic note_mismatch(input string tag, input grant_t want, input grant_t got);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS)
      $display("%0t %s: expected granted/index/size %0d/%0d/%0d, got %0d/%0d/%0d",
               $realtime, tag, want.granted, want.hole_index, want.size_before,
               got.granted, got.hole_index, got.size_before);
  endtask

  // Offer one request on the input channel and record its expected result
  task automatic send_item(input logic kind, input logic [SLOT_W-1:0] slot,
                           input logic [SIZE_W-1:0] amount, input bit typed, input grant_t want);
    grant_t g;
    bit     has;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid  <= 1'b1;
    in_if.kind   <= kind;
    in_if.slot   <= slot;
    in_if.amount <= amount;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    has = predict_fit(kind, slot, amount, g);
    if (has) grant_q.push_back(typed ? want : g);
    n_items++;
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic quiesce();
    @(negedge clk);
    in_if.valid <= 1'b0;
    wait (grant_q.size() == 0);
  endtask

  // Write one register once the block is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    quiesce();
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    if (idx == CFG_FIT_POLICY) fit_pol = data[POL_W-1:0];
    else if (idx == CFG_HOLE_COUNT) hole_cnt = data[HC_W-1:0];
    n_cfg++;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Drive result ready: random stalls, plus a long hold-off on demand
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin : result_mon
    grant_t got;
    grant_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.granted     = out_if.granted;
      got.hole_index  = out_if.hole_index;
      got.size_before = out_if.size_before;
      n_results++;
      if (got.granted) n_grants++;
      if (grant_q.size() == 0) begin
        note_mismatch("unexpected result", '0, got);
      end else begin
        want = grant_q.pop_front();
        if (got !== want) note_mismatch("result mismatch", want, got);
      end
    end
  end

  // End the run when nothing has moved for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
    $display("tb_top: errors");
    $finish;
  end

  initial begin : stimulus
    logic                  kind;
    logic [SLOT_W-1:0]     slot;
    logic [SIZE_W-1:0]     amount;
    logic [POL_W-1:0]      pol;
    logic [HC_W-1:0]       hc;
    int                    r;
    int                    lim;
    int                    done;
    int                    seg;
    int                    seg_len;

    // Directed rows: fresh table, extremes, each policy, tie, and register corner cases
    dir_tbl.push_back(mk_row(ROW_REQ, 0, 0, 1'b1, 1, 0, 0));
    dir_tbl.push_back(mk_row(ROW_REQ, 0, 1, 1'b1, 0, 0, 0));
    dir_tbl.push_back(mk_row(ROW_REQ, 0, 65535, 1'b1, 0, 0, 0));
    dir_tbl.push_back(mk_row(ROW_LOAD, 0, 100));
    dir_tbl.push_back(mk_row(ROW_LOAD, 15, 65535));
    dir_tbl.push_back(mk_row(ROW_LOAD, 3, 40));
    dir_tbl.push_back(mk_row(ROW_LOAD, 7, 60));
    dir_tbl.push_back(mk_row(ROW_REQ, 0, 50));
    dir_tbl.push_back(mk_row(ROW_REQ, 0, 65535, 1'b1, 1, 15, 65535));
    dir_tbl.push_back(mk_row(ROW_CFG, CFG_FIT_POLICY, POLICY_BEST));
    dir_tbl.push_back(mk_row(ROW_REQ, 0, 30));
    dir_tbl.push_back(mk_row(ROW_REQ, 9, 0));
    dir_tbl.push_back(mk_row(ROW_LOAD, 2, 77));
    dir_tbl.push_back(mk_row(ROW_LOAD, 5, 77));
    dir_tbl.push_back(mk_row(ROW_REQ, 0, 77));
    dir_tbl.push_back(mk_row(ROW_CFG, CFG_FIT_POLICY, POLICY_WORST));
    dir_tbl.push_back(mk_row(ROW_LOAD, 15, 65535));
    dir_tbl.push_back(mk_row(ROW_REQ, 0, 1000));
    dir_tbl.push_back(mk_row(ROW_REQ, 0, 65535, 1'b1, 0, 0, 0));
    dir_tbl.push_back(mk_row(ROW_CFG, CFG_FIT_POLICY, POLICY_SPARE));
    dir_tbl.push_back(mk_row(ROW_REQ, 0, 10));
    dir_tbl.push_back(mk_row(ROW_CFG, CFG_HOLE_COUNT, 0));
    dir_tbl.push_back(mk_row(ROW_REQ, 0, 0, 1'b1, 0, 0, 0));
    dir_tbl.push_back(mk_row(ROW_CFG, CFG_HOLE_COUNT, 1));
    dir_tbl.push_back(mk_row(ROW_REQ, 0, 10));
    dir_tbl.push_back(mk_row(ROW_CFG, CFG_HOLE_COUNT, 4));
    dir_tbl.push_back(mk_row(ROW_LOAD, 12, 500));
    dir_tbl.push_back(mk_row(ROW_REQ, 0, 400));
    dir_tbl.push_back(mk_row(ROW_CFG, CFG_HOLE_COUNT, 31));
    dir_tbl.push_back(mk_row(ROW_CFG, CFG_FIT_POLICY, POLICY_BEST));
    dir_tbl.push_back(mk_row(ROW_REQ, 6, 400));
    dir_tbl.push_back(mk_row(ROW_CFG, CFG_HOLE_COUNT, 16));

    // Hold reset, then release on a falling edge
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Walk the directed table
    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].op == ROW_CFG)
        write_reg(dir_tbl[i].cfg_idx, dir_tbl[i].cfg_data);
      else
        send_item(dir_tbl[i].op == ROW_REQ ? KIND_REQUEST : KIND_LOAD, dir_tbl[i].slot,
                  dir_tbl[i].amount, dir_tbl[i].typed, dir_tbl[i].want);
    end

    // Random traffic in three idle profiles, with a fresh setting per segment
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 10; recv_idle_pct = 59; end
        1:       begin send_idle_pct = 59; recv_idle_pct = 10; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      done = 0;
      seg  = 0;
      while (done < PHASE_ITEMS) begin
        pol = POL_W'($urandom_range(0, 3));
        r   = $urandom_range(0, 9);
        if (seg == 0)   hc = (ph == 1) ? 5'd1 : 5'd16;
        else if (r < 6) hc = HC_W'($urandom_range(1, 16));
        else if (r == 6) hc = 5'd16;
        else if (r == 7) hc = 5'd1;
        else if (r == 8) hc = HC_W'($urandom_range(17, 31));
        else            hc = 5'd0;
        write_reg(CFG_FIT_POLICY, {{(CFG_DATA_W-POL_W){1'b0}}, pol});
        write_reg(CFG_HOLE_COUNT, hc);
        // Stall the receiver long enough for the block to back up
        if (ph == 2 && seg == 1) hold_reqs++;
        lim = (hc == 0) ? 0 : ((hc > 16) ? 15 : int'(hc) - 1);
        seg_len = $urandom_range(40, 120);
        for (int k = 0; k < seg_len && done < PHASE_ITEMS; k++) begin
          // Pause the sender once until the block has drained
          if (ph == 1 && done == PHASE_ITEMS / 2) quiesce();
          kind = ($urandom_range(0, 99) < 45) ? KIND_LOAD : KIND_REQUEST;
          if ($urandom_range(0, 9) < 8) slot = SLOT_W'($urandom_range(0, lim));
          else                          slot = SLOT_W'($urandom_range(0, 15));
          r = $urandom_range(0, 19);
          if (kind == KIND_LOAD) begin
            if (r < 2)       amount = '0;
            else if (r < 4)  amount = '1;
            else if (r < 12) amount = SIZE_W'($urandom_range(0, 65535));
            else             amount = SIZE_W'($urandom_range(0, 4095));
          end else begin
            if (r < 2)       amount = '0;
            else if (r < 3)  amount = '1;
            else if (r < 12) amount = SIZE_W'($urandom_range(1, 1023));
            else             amount = SIZE_W'($urandom_range(0, 65535));
          end
          send_item(kind, slot, amount, 1'b0, '0);
          done++;
        end
        seg++;
      end
    end

    // Drain and give the block time to flush anything left
    quiesce();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("summary: %0d input requests, %0d register writes, %0d results checked",
             n_items, n_cfg, n_results);
    $display("summary: %0d granted, %0d refused, over all policies and hole counts 0 to 31",
             n_grants, n_results - n_grants);
    if (err_cnt == 0 && grant_q.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("failures: %0d mismatches, %0d results never returned", err_cnt, grant_q.size());
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/hfa_pkg.sv
rtl/hfa_channels.sv
rtl/hfa_hole_store.sv
rtl/hfa_fit_unit.sv
rtl/hfa_ctrl.sv
rtl/hole_fit_allocator.sv
rtl/hfa_checker.sv
verif/tb_top.sv
